// ===== rtl/tspi_pkg.sv =====
package tspi_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned PixW   = 3 * ChanW;
  localparam int unsigned FracW  = 8;
  localparam int unsigned LumaW  = 16;
  localparam int unsigned SumW   = 17;

  // luma weights, sum to 256
  localparam logic [7:0] LumaR = 8'd54;
  localparam logic [7:0] LumaG = 8'd183;
  localparam logic [7:0] LumaB = 8'd19;

  // rounding constant for a product scaled by 256
  localparam logic [SumW-1:0] Round = SumW'(128);
  localparam logic [FracW:0] One = (FracW+1)'(256);

  // per-channel stage control
  typedef struct packed {
    logic             en3;
    logic             en4;
    logic             tri_sel;
    logic [FracW-1:0] frac_u;
    logic [FracW-1:0] frac_v;
  } tspi_ctl_t;

  // ((256-f)*a + f*b + 128) >> 8
  function automatic logic [ChanW-1:0] lerp8(input logic [ChanW-1:0] a,
                                             input logic [ChanW-1:0] b,
                                             input logic [FracW-1:0] f);
    logic [SumW-1:0] s;
    s = SumW'(One - {1'b0, f}) * SumW'(a) + SumW'(f) * SumW'(b) + Round;
    return s[15:8];
  endfunction

endpackage

// ===== rtl/tspi_chan.sv =====
module tspi_chan
  import tspi_pkg::*;
(
  input  logic             clk_i,
  input  tspi_ctl_t        ctl_i,
  input  logic [ChanW-1:0] a_i,
  input  logic [ChanW-1:0] b_i,
  input  logic [ChanW-1:0] c_i,
  input  logic [ChanW-1:0] d_i,
  output logic [ChanW-1:0] pix_o
);

  logic [FracW:0]   wa, wb, wc, wd;
  logic [SumW-1:0]  tri_sum;
  logic [SumW-1:0]  tri_sum_d, tri_sum_q;
  logic [ChanW-1:0] top_q, bot_q;
  logic             tri_q;
  logic [FracW-1:0] v_q;
  logic [ChanW-1:0] pix_d, pix_q;

  // triangle weights
  always_comb begin
    wb = '0;
    wc = '0;
    if (ctl_i.frac_u > ctl_i.frac_v) begin
      wa = One - {1'b0, ctl_i.frac_u};
      wb = {1'b0, ctl_i.frac_u - ctl_i.frac_v};
      wd = {1'b0, ctl_i.frac_v};
    end else begin
      wa = One - {1'b0, ctl_i.frac_v};
      wc = {1'b0, ctl_i.frac_v - ctl_i.frac_u};
      wd = {1'b0, ctl_i.frac_u};
    end
  end

  assign tri_sum = SumW'(wa) * SumW'(a_i) + SumW'(wb) * SumW'(b_i)
                 + SumW'(wc) * SumW'(c_i) + SumW'(wd) * SumW'(d_i);
  assign tri_sum_d = tri_sum + Round;

  // stage 3: triangle sum or horizontal row blends
  always_ff @(posedge clk_i) begin
    if (ctl_i.en3) begin
      tri_sum_q <= tri_sum_d;
      top_q     <= lerp8(a_i, b_i, ctl_i.frac_u);
      bot_q     <= lerp8(c_i, d_i, ctl_i.frac_u);
      tri_q     <= ctl_i.tri_sel;
      v_q       <= ctl_i.frac_v;
    end
  end

  // stage 4: final scale or vertical blend
  assign pix_d = tri_q ? tri_sum_q[15:8] : lerp8(top_q, bot_q, v_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en4) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

// ===== rtl/triangle_split_pixel_interpolator.sv =====
// Edge-directed 2x2 pixel interpolator.
// Input stream s_axis carries one item per output pixel: the four corner
// pixels of a 2x2 neighbourhood and 8-bit horizontal and vertical fractions.
// Output stream m_axis carries the interpolated RGB pixel.
// The luma of each corner is compared to the rounded mean luma; the pattern
// picks either a triangle blend (optionally mirrored left to right) or a
// rounded bilinear blend, one choice shared by all three channels.
// Four register stages: luma, mean and pattern decode, first blend,
// final blend into the output register; m_axis_tvalid_o is the valid bit
// of the last stage. One item is accepted every cycle while the output
// flows.
// When the receiver stalls, a stage holds its item only while it and every
// later stage are full, so bubbles close up; the input is held off once all
// stages are full. Nothing is lost or repeated across a stall.
// Reset clears all stage valid bits; the data registers are not reset.
module triangle_split_pixel_interpolator
  import tspi_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // top_left[23:0], top_right[47:24], bottom_left[71:48],
  // bottom_right[95:72], frac_u[103:96], frac_v[111:104]
  input  logic [111:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_pixel[23:0]
  output logic [23:0]  m_axis_tdata_o
);

  // single-dark and single-bright corner patterns
  localparam logic [3:0] CodeTlLow  = 4'd1;
  localparam logic [3:0] CodeTrLow  = 4'd2;
  localparam logic [3:0] CodeBlLow  = 4'd4;
  localparam logic [3:0] CodeBrHigh = 4'd7;
  localparam logic [3:0] CodeBrLow  = 4'd8;
  localparam logic [3:0] CodeBlHigh = 4'd11;
  localparam logic [3:0] CodeTrHigh = 4'd13;
  localparam logic [3:0] CodeTlHigh = 4'd14;

  function automatic logic [LumaW-1:0] luma(input logic [PixW-1:0] p);
    return LumaW'(p[23:16]) * LumaW'(LumaR) + LumaW'(p[15:8]) * LumaW'(LumaG)
         + LumaW'(p[7:0]) * LumaW'(LumaB);
  endfunction

  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d, v2_d, v3_d, v4_d;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [PixW-1:0]  p1_q [4];
  logic [LumaW-1:0] y1_q [4];
  logic [FracW-1:0] u1_q, fv1_q;

  logic [PixW-1:0]  p2_q [4];
  logic [FracW-1:0] u2_q, fv2_q;
  logic             tri2_q;

  logic [17:0]      luma_sum;
  logic [LumaW-1:0] mean;
  logic [3:0]       code;
  logic             mirror, tri_sel;

  tspi_ctl_t ctl;

  // pipeline flow control
  assign rdy4 = !v4_q || m_axis_tready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready_o = rdy1;

  assign v1_d = rdy1 ? s_axis_tvalid_i : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;
  assign v4_d = rdy4 ? v3_q : v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  // stage 1: corner lumas
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      for (int i = 0; i < 4; i++) begin
        p1_q[i] <= s_axis_tdata_i[i*PixW +: PixW];
        y1_q[i] <= luma(s_axis_tdata_i[i*PixW +: PixW]);
      end
      u1_q  <= s_axis_tdata_i[103:96];
      fv1_q <= s_axis_tdata_i[111:104];
    end
  end

  // stage 2: rounded mean, pattern code, mirroring
  assign luma_sum = 18'(y1_q[0]) + 18'(y1_q[1]) + 18'(y1_q[2]) + 18'(y1_q[3])
                  + 18'd2;
  assign mean = luma_sum[17:2];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      code[i] = y1_q[i] < mean;
    end
  end

  always_comb begin
    mirror  = 1'b0;
    tri_sel = 1'b0;
    unique case (code) inside
      CodeTlLow, CodeBrHigh, CodeBrLow, CodeTlHigh: begin
        mirror  = 1'b1;
        tri_sel = 1'b1;
      end
      CodeTrLow, CodeBlLow, CodeBlHigh, CodeTrHigh: begin
        tri_sel = 1'b1;
      end
      default: begin
        tri_sel = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      p2_q[0] <= mirror ? p1_q[1] : p1_q[0];
      p2_q[1] <= mirror ? p1_q[0] : p1_q[1];
      p2_q[2] <= mirror ? p1_q[3] : p1_q[2];
      p2_q[3] <= mirror ? p1_q[2] : p1_q[3];
      u2_q    <= mirror ? ~u1_q : u1_q;
      fv2_q   <= fv1_q;
      tri2_q  <= tri_sel;
    end
  end

  // stages 3 and 4: per-channel blends
  assign ctl.en3     = rdy3;
  assign ctl.en4     = rdy4;
  assign ctl.tri_sel = tri2_q;
  assign ctl.frac_u  = u2_q;
  assign ctl.frac_v  = fv2_q;

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    tspi_chan u_chan (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .a_i   (p2_q[0][ch*ChanW +: ChanW]),
      .b_i   (p2_q[1][ch*ChanW +: ChanW]),
      .c_i   (p2_q[2][ch*ChanW +: ChanW]),
      .d_i   (p2_q[3][ch*ChanW +: ChanW]),
      .pix_o (m_axis_tdata_o[ch*ChanW +: ChanW])
    );
  end

  assign m_axis_tvalid_o = v4_q;

endmodule
